// File: rtl/rfl_pkg.sv
package rfl_pkg;

  // width of the internal saturating counters, 16 to 64
  localparam int COUNT_WIDTH = 32;
  localparam int SEQ_W       = 16;
  localparam int OUT_CNT_W   = 32;
  localparam int INC_W       = 18;
  localparam int SUM_W       = COUNT_WIDTH + INC_W + 1;

  localparam logic [SEQ_W-1:0]       SEQ_TOP   = 16'hFFFF;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  localparam logic ACT_PACKET = 1'b0;
  localparam logic ACT_FLUSH  = 1'b1;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  typedef struct packed {
    logic        action;
    logic [15:0] seq_num;
    logic [31:0] session_id;
    logic [31:0] timestamp;
    logic        marker;
    logic [7:0]  packet_blocks;
    logic [15:0] image_blocks;
  } rfl_in_t;

  typedef struct packed {
    logic        dropped;
    logic        closed_previous;
    logic        opened_frame;
    logic        closed_frame;
    logic [31:0] lost_count;
    logic [31:0] received_count;
    logic [31:0] dropped_count;
    logic [31:0] frame_count;
    logic [31:0] blocks_in_count;
    logic [31:0] blocks_dropped_count;
    logic [31:0] blocks_expected_count;
  } rfl_out_t;

  // accumulator never exceeds COUNT_MAX, so one add and compare does it
  function automatic cnt_t sat_add(input cnt_t acc, input logic [INC_W-1:0] inc);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(acc) + SUM_W'(inc);
    if (sum > SUM_W'(COUNT_MAX)) begin
      return COUNT_MAX;
    end
    return sum[COUNT_WIDTH-1:0];
  endfunction

  function automatic logic [OUT_CNT_W-1:0] report(input cnt_t cnt);
    logic [63:0] wide;
    wide = 64'(cnt);
    return wide[OUT_CNT_W-1:0];
  endfunction

endpackage

// File: rtl/rfl_in_if.sv
interface rfl_in_if;
  import rfl_pkg::*;

  logic    valid;
  logic    ready;
  rfl_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/rfl_out_if.sv
interface rfl_out_if;
  import rfl_pkg::*;

  logic     valid;
  logic     ready;
  rfl_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/rtp_frame_loss_tracker.sv
// each result is registered in the main output entry, or in the skid entry while the output stalls
// throughput: one item per cycle while the skid entry is empty; tracking state updates in the transfer cycle
// a two-entry output register (main plus skid) decouples in_ready from out_ready
// reset: synchronous active-low rst_n clears tracking state, counters and
// output valids; payload registers are not reset
module rtp_frame_loss_tracker (
  input  logic      clk,
  input  logic      rst_n,
  rfl_in_if.sink    in_ch,
  rfl_out_if.source out_ch
);
  import rfl_pkg::*;

  logic              started_r;
  logic [31:0]       session_r;
  logic [SEQ_W-1:0]  exp_seq_r;
  logic [SEQ_W-1:0]  last_seq_r;
  logic              frame_open_r;
  logic [31:0]       frame_stamp_r;
  logic [15:0]       last_iblk_r;
  cnt_t              lost_r, recv_r, drop_r, frame_r, bin_r, bdrop_r, bexp_r;

  logic              out_valid_r, skid_valid_r;
  rfl_out_t          out_r, skid_r;

  rfl_in_t           pkt;
  logic              accept, is_pkt, resync, new_stamp;
  logic              drop, prev_close, open_f, close_f;
  logic [SEQ_W-1:0]  exp_base, back, exp_seq_nxt;
  logic [SEQ_W:0]    fwd;
  logic [SEQ_W:0]    lost_inc;
  logic [1:0]        n_close;
  logic [15:0]       close_blocks;
  logic [INC_W-1:0]  bexp_inc;
  logic              frame_open_nxt;
  cnt_t              lost_nxt, recv_nxt, drop_nxt, frame_nxt, bin_nxt, bdrop_nxt, bexp_nxt;
  rfl_out_t          res;

  assign pkt    = in_ch.data;
  assign accept = in_ch.valid && in_ch.ready;
  assign is_pkt = (pkt.action == ACT_PACKET);

  // sequence tracking
  always_comb begin
    resync   = started_r && (session_r != pkt.session_id);
    fwd      = (SEQ_W+1)'(SEQ_TOP) - (SEQ_W+1)'(exp_seq_r) + (SEQ_W+1)'(pkt.seq_num);
    back     = exp_seq_r - pkt.seq_num;
    lost_inc = '0;
    exp_base = exp_seq_r;
    if (!started_r || resync) begin
      exp_base = pkt.seq_num;
    end else if (exp_seq_r < pkt.seq_num) begin
      lost_inc = (SEQ_W+1)'(pkt.seq_num - exp_seq_r);
      exp_base = pkt.seq_num;
    end else if (exp_seq_r > pkt.seq_num) begin
      // wrap-around jump only when shorter than stepping back
      if (fwd < (SEQ_W+1)'(back)) begin
        lost_inc = fwd + 1'b1;
        exp_base = pkt.seq_num;
      end
    end
    exp_seq_nxt = exp_base + 1'b1;
  end

  // frame tracking
  always_comb begin
    new_stamp  = frame_open_r && (pkt.timestamp != frame_stamp_r);
    drop       = is_pkt && new_stamp && (pkt.seq_num < last_seq_r);
    prev_close = is_pkt ? (new_stamp && !drop) : frame_open_r;
    open_f     = is_pkt && !drop && (!frame_open_r || prev_close);
    close_f    = is_pkt && !drop && pkt.marker;
    if (!is_pkt) begin
      frame_open_nxt = 1'b0;
    end else if (drop) begin
      frame_open_nxt = frame_open_r;
    end else begin
      frame_open_nxt = !pkt.marker;
    end
    n_close      = {1'b0, prev_close} + {1'b0, close_f};
    close_blocks = is_pkt ? pkt.image_blocks : last_iblk_r;
    case (n_close)
      2'd0:    bexp_inc = '0;
      2'd1:    bexp_inc = INC_W'(close_blocks);
      2'd2:    bexp_inc = INC_W'({close_blocks, 1'b0});
      default: bexp_inc = '0;
    endcase
  end

  // counters
  always_comb begin
    lost_nxt  = is_pkt ? sat_add(lost_r, INC_W'(lost_inc)) : lost_r;
    recv_nxt  = sat_add(recv_r, INC_W'(is_pkt && !drop));
    drop_nxt  = sat_add(drop_r, INC_W'(drop));
    frame_nxt = sat_add(frame_r, INC_W'(n_close));
    bin_nxt   = (is_pkt && !drop) ? sat_add(bin_r, INC_W'(pkt.packet_blocks)) : bin_r;
    bdrop_nxt = drop ? sat_add(bdrop_r, INC_W'(pkt.packet_blocks)) : bdrop_r;
    bexp_nxt  = sat_add(bexp_r, bexp_inc);

    res.dropped               = drop;
    res.closed_previous       = prev_close;
    res.opened_frame          = open_f;
    res.closed_frame          = close_f;
    res.lost_count            = report(lost_nxt);
    res.received_count        = report(recv_nxt);
    res.dropped_count         = report(drop_nxt);
    res.frame_count           = report(frame_nxt);
    res.blocks_in_count       = report(bin_nxt);
    res.blocks_dropped_count  = report(bdrop_nxt);
    res.blocks_expected_count = report(bexp_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r     <= 1'b0;
      session_r     <= '0;
      exp_seq_r     <= '0;
      last_seq_r    <= '0;
      frame_open_r  <= 1'b0;
      frame_stamp_r <= '0;
      last_iblk_r   <= '0;
      lost_r        <= '0;
      recv_r        <= '0;
      drop_r        <= '0;
      frame_r       <= '0;
      bin_r         <= '0;
      bdrop_r       <= '0;
      bexp_r        <= '0;
    end else if (accept) begin
      frame_open_r <= frame_open_nxt;
      frame_r      <= frame_nxt;
      bexp_r       <= bexp_nxt;
      if (open_f) begin
        frame_stamp_r <= pkt.timestamp;
      end
      if (is_pkt) begin
        started_r   <= 1'b1;
        session_r   <= pkt.session_id;
        exp_seq_r   <= exp_seq_nxt;
        last_seq_r  <= pkt.seq_num;
        last_iblk_r <= pkt.image_blocks;
        lost_r      <= lost_nxt;
        recv_r      <= recv_nxt;
        drop_r      <= drop_nxt;
        bin_r       <= bin_nxt;
        bdrop_r     <= bdrop_nxt;
      end
    end
  end

  // output register with skid entry
  assign in_ch.ready  = !skid_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ch.ready) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (accept) begin
        out_r <= res;
      end
    end else if (accept) begin
      skid_r <= res;
    end
  end

endmodule

// File: test/rtp_frame_loss_tracker_test.sv
module rtp_frame_loss_tracker_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rfl_pkg::*;

  localparam longint unsigned CNT_TOP = {64{1'b1}} >> (64 - COUNT_WIDTH);

  logic clk = 1'b0;
  logic rst_n;

  rfl_in_if  in_ch ();
  rfl_out_if out_ch ();

  rtp_frame_loss_tracker DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #2 clk = ~clk;

  rfl_in_t  packets_to_send[$];
  rfl_out_t pending_results[$];

  int queued_n   = 0;
  int accepted_n = 0;
  int n_checked  = 0;
  int err_count  = 0;
  int gap_left   = 0;
  int stall_left = 0;
  bit in_took    = 1'b0;
  bit quiet      = 1'b0;

  // tracker mirror
  logic        trk_started  = 1'b0;
  logic [31:0] trk_session  = '0;
  logic [15:0] trk_expect   = '0;
  logic [15:0] trk_last_seq = '0;
  logic        trk_open     = 1'b0;
  logic [31:0] trk_stamp    = '0;
  logic [15:0] trk_last_img = '0;
  longint unsigned tot_lost = 0, tot_recv = 0, tot_drop = 0, tot_frames = 0;
  longint unsigned tot_blk_in = 0, tot_blk_drop = 0, tot_blk_exp = 0;

  int n_drops = 0, n_wraps = 0, n_resyncs = 0, n_flush_closes = 0;

  function automatic longint unsigned sat_sum(input longint unsigned acc,
                                              input longint unsigned inc);
    if (acc > CNT_TOP) acc = CNT_TOP;
    if (inc > CNT_TOP - acc) return CNT_TOP;
    return acc + inc;
  endfunction

  function automatic void end_frame(input logic [15:0] img);
    tot_frames  = sat_sum(tot_frames, 64'd1);
    tot_blk_exp = sat_sum(tot_blk_exp, 64'(img));
    trk_open    = 1'b0;
  endfunction

  function automatic rfl_out_t track_packet(input rfl_in_t it);
    rfl_out_t    r;
    logic [15:0] prev_seq;
    logic        resync;
    int unsigned fwd, back;
    r = '0;
    resync = 1'b0;
    if (it.action == ACT_FLUSH) begin
      if (trk_open) begin
        end_frame(trk_last_img);
        r.closed_previous = 1'b1;
        n_flush_closes++;
      end
    end else begin
      prev_seq = trk_last_seq;
      trk_last_seq = it.seq_num;
      trk_last_img = it.image_blocks;
      if (!trk_started) begin
        trk_started = 1'b1;
        trk_session = it.session_id;
        trk_expect  = it.seq_num;
      end
      if (trk_session != it.session_id) begin
        trk_session = it.session_id;
        trk_expect  = it.seq_num;
        resync = 1'b1;
        n_resyncs++;
      end
      if (!resync) begin
        if (trk_expect < it.seq_num) begin
          tot_lost = sat_sum(tot_lost, 64'(it.seq_num) - 64'(trk_expect));
          trk_expect = it.seq_num;
        end else if (trk_expect > it.seq_num) begin
          fwd  = 32'd65535 - 32'(trk_expect) + 32'(it.seq_num);
          back = 32'(trk_expect) - 32'(it.seq_num);
          // short forward leap across zero counts as loss, else it is a late packet
          if (fwd < back) begin
            tot_lost = sat_sum(tot_lost, 64'(fwd) + 64'd1);
            trk_expect = it.seq_num;
            n_wraps++;
          end
        end
      end
      trk_expect = trk_expect + 16'd1;

      if (trk_open && it.timestamp != trk_stamp) begin
        if (it.seq_num < prev_seq) begin
          tot_drop     = sat_sum(tot_drop, 64'd1);
          tot_blk_drop = sat_sum(tot_blk_drop, 64'(it.packet_blocks));
          r.dropped = 1'b1;
          n_drops++;
        end else begin
          end_frame(it.image_blocks);
          r.closed_previous = 1'b1;
        end
      end
      if (!r.dropped) begin
        if (!trk_open) begin
          trk_stamp = it.timestamp;
          trk_open  = 1'b1;
          r.opened_frame = 1'b1;
        end
        tot_recv   = sat_sum(tot_recv, 64'd1);
        tot_blk_in = sat_sum(tot_blk_in, 64'(it.packet_blocks));
        if (it.marker) begin
          end_frame(it.image_blocks);
          r.closed_frame = 1'b1;
        end
      end
    end
    r.lost_count            = tot_lost[31:0];
    r.received_count        = tot_recv[31:0];
    r.dropped_count         = tot_drop[31:0];
    r.frame_count           = tot_frames[31:0];
    r.blocks_in_count       = tot_blk_in[31:0];
    r.blocks_dropped_count  = tot_blk_drop[31:0];
    r.blocks_expected_count = tot_blk_exp[31:0];
    return r;
  endfunction

  task automatic flag_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t: result %0d, %s: got %0h, expected %0h", $realtime, n_checked, field,
             got, want);
    err_count++;
  endtask

  task automatic check_result(input rfl_out_t got, input rfl_out_t want);
    if (got.dropped !== want.dropped)
      flag_mismatch("dropped", 32'(got.dropped), 32'(want.dropped));
    if (got.closed_previous !== want.closed_previous)
      flag_mismatch("closed_previous", 32'(got.closed_previous),
                    32'(want.closed_previous));
    if (got.opened_frame !== want.opened_frame)
      flag_mismatch("opened_frame", 32'(got.opened_frame), 32'(want.opened_frame));
    if (got.closed_frame !== want.closed_frame)
      flag_mismatch("closed_frame", 32'(got.closed_frame), 32'(want.closed_frame));
    if (got.lost_count !== want.lost_count)
      flag_mismatch("lost_count", got.lost_count, want.lost_count);
    if (got.received_count !== want.received_count)
      flag_mismatch("received_count", got.received_count, want.received_count);
    if (got.dropped_count !== want.dropped_count)
      flag_mismatch("dropped_count", got.dropped_count, want.dropped_count);
    if (got.frame_count !== want.frame_count)
      flag_mismatch("frame_count", got.frame_count, want.frame_count);
    if (got.blocks_in_count !== want.blocks_in_count)
      flag_mismatch("blocks_in_count", got.blocks_in_count, want.blocks_in_count);
    if (got.blocks_dropped_count !== want.blocks_dropped_count)
      flag_mismatch("blocks_dropped_count", got.blocks_dropped_count,
                    want.blocks_dropped_count);
    if (got.blocks_expected_count !== want.blocks_expected_count)
      flag_mismatch("blocks_expected_count", got.blocks_expected_count,
                    want.blocks_expected_count);
  endtask

  function automatic rfl_in_t mk_packet(input logic [15:0] seq, input logic [31:0] sess,
                                        input logic [31:0] stamp, input logic mark,
                                        input logic [7:0] pblk, input logic [15:0] iblk);
    rfl_in_t it;
    it.action        = ACT_PACKET;
    it.seq_num       = seq;
    it.session_id    = sess;
    it.timestamp     = stamp;
    it.marker        = mark;
    it.packet_blocks = pblk;
    it.image_blocks  = iblk;
    return it;
  endfunction

  // flush carries junk in the packet fields
  function automatic rfl_in_t mk_flush();
    rfl_in_t it;
    it = mk_packet(16'($urandom), $urandom, $urandom, 1'($urandom_range(0, 1)),
                   8'($urandom), 16'($urandom));
    it.action = ACT_FLUSH;
    return it;
  endfunction

  task automatic queue_item(input rfl_in_t it);
    packets_to_send.push_back(it);
    queued_n++;
  endtask

  task automatic wait_drained();
    while (accepted_n != queued_n || pending_results.size() != 0) @(negedge clk);
  endtask

  // mostly well-formed frames, with gaps, late arrivals, session changes, flushes, noise
  task automatic queue_traffic(input int n);
    int          made, r, len, k;
    logic [15:0] seq, img;
    logic [31:0] sess, stamp;
    made  = 0;
    sess  = $urandom;
    seq   = 16'($urandom);
    stamp = $urandom;
    while (made < n) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        queue_item(mk_flush());
        made++;
      end else if (r < 10) begin
        queue_item(mk_packet(16'($urandom), $urandom, $urandom, 1'($urandom_range(0, 1)),
                             8'($urandom), 16'($urandom)));
        made++;
      end else if (r < 14) begin
        sess = $urandom;
        seq  = 16'($urandom);
      end else begin
        len   = $urandom_range(1, 6);
        stamp = ($urandom_range(0, 9) == 0) ? $urandom : stamp + $urandom_range(1, 3000);
        img   = 16'($urandom);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 9) == 0) seq = seq + 16'($urandom_range(1, 40));
          if (k != 0 && $urandom_range(0, 7) == 0) begin
            // stray from an older frame, below the previous number
            queue_item(mk_packet(seq - 16'($urandom_range(2, 9)), sess, stamp - 1,
                                 1'($urandom_range(0, 1)), 8'($urandom), img));
            made++;
          end
          queue_item(mk_packet(seq, sess, stamp,
                               (k == len - 1) && ($urandom_range(0, 4) != 0),
                               8'($urandom), img));
          seq++;
          made++;
        end
      end
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_took) begin
      if (gap_left != 0 && !quiet) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (packets_to_send.size() != 0) begin
        in_ch.data  <= packets_to_send.pop_front();
        in_ch.valid <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 16);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (stall_left != 0 && !quiet) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (!quiet && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 16);
    end
  end

  // monitor
  always @(posedge clk) begin
    rfl_out_t want;
    in_took = 1'b0;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        in_took = 1'b1;
        accepted_n++;
        pending_results.push_back(track_packet(in_ch.data));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("transfer with no result pending", out_ch.data.lost_count, '0);
        end else begin
          want = pending_results.pop_front();
          check_result(out_ch.data, want);
        end
        n_checked++;
      end
    end
  end

  initial begin
    #2000000;
    $display("timeout with %0d results still pending", pending_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    queue_item(mk_flush());                                                   // nothing open
    queue_item(mk_packet(16'd65534, 32'hFFFF_FFFF, 32'd0, 1'b0, 8'd255, 16'hFFFF));
    queue_item(mk_packet(16'd65535, 32'hFFFF_FFFF, 32'd0, 1'b0, 8'd0, 16'd0));
    queue_item(mk_packet(16'd0, 32'hFFFF_FFFF, 32'd0, 1'b1, 8'd17, 16'd900));
    queue_item(mk_packet(16'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 8'd3, 16'd900));
    queue_item(mk_packet(16'd6, 32'hFFFF_FFFF, 32'd100, 1'b0, 8'd4, 16'd901));  // closes by stamp
    queue_item(mk_packet(16'd4, 32'hFFFF_FFFF, 32'd200, 1'b0, 8'd9, 16'd902));  // late
    queue_item(mk_packet(16'd8, 32'hFFFF_FFFF, 32'd100, 1'b1, 8'd1, 16'd903));
    queue_item(mk_flush());
    queue_item(mk_packet(16'd9, 32'hFFFF_FFFF, 32'd300, 1'b0, 8'd2, 16'd1234));
    queue_item(mk_flush());                                                   // closes open frame
    queue_item(mk_packet(16'd40000, 32'd0, 32'd400, 1'b0, 8'd5, 16'd77));       // new session
    queue_item(mk_packet(16'd40001, 32'd0, 32'd400, 1'b0, 8'd6, 16'd77));
    queue_item(mk_packet(16'd65530, 32'h1234_5678, 32'd500, 1'b0, 8'd7, 16'd50));
    queue_item(mk_packet(16'd3, 32'h1234_5678, 32'd500, 1'b0, 8'd8, 16'd50));    // wrap loss
    queue_item(mk_packet(16'd2, 32'h1234_5678, 32'd600, 1'b1, 8'd128, 16'd51));  // late
    queue_item(mk_packet(16'd10, 32'h1234_5678, 32'd600, 1'b1, 8'd11, 16'd52));
    queue_item(mk_packet(16'd65535, 32'h1234_5678, 32'd700, 1'b0, 8'd12, 16'hFFFF));
    queue_item(mk_packet(16'd0, 32'h1234_5678, 32'd700, 1'b1, 8'd255, 16'hFFFF));
    queue_item(mk_flush());
    queue_item(mk_packet(16'd0, 32'h1234_5678, 32'd800, 1'b0, 8'd0, 16'd0));
    queue_item(mk_flush());
    wait_drained();

    queue_traffic(350);
    // sender holds until the tracker has answered everything
    wait_drained();

    quiet = 1'b1;
    queue_traffic(50);
    wait_drained();
    repeat (5) @(posedge clk);

    $display("checked %0d results: %0d late drops, %0d wrap-around losses,", n_checked,
             n_drops, n_wraps);
    $display("  %0d session changes, %0d frames closed by flush", n_resyncs, n_flush_closes);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
